### hdl/wsfr_pkg.sv
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

  // Limit used when the configured limit is zero
  localparam logic [31:0] DEFAULT_MAX_FRAME = 32'd1048576;
  localparam logic [31:0] LIMIT_RESET       = 32'd1048576;

  // Opcodes that the receiver acts on
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_PING  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_FRAGMENT = 3'd1,
    ERR_TOO_LONG = 3'd2,
    ERR_UNMASKED = 3'd3,
    ERR_OPCODE   = 3'd4
  } err_t;

  // One queued result: payload byte still masked, key byte alongside
  typedef struct packed {
    kind_t      kind;
    logic       has_data;
    logic [7:0] raw;
    logic [7:0] key;
    logic       frame_end;
    err_t       error_code;
  } entry_t;

  // Push request from the parser into the queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

### hdl/wsfr_front.sv
// Header parser and payload classifier of the WebSocket frame receiver.
module wsfr_front
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_rx_byte,
  output logic        in_stall,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        q_full,
  output push_t       push
);

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT16   = 6'b000100,
    PH_EXT64   = 6'b001000,
    PH_MASK    = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [2:0]  hbc_r, hbc_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        stopped_r, stopped_nxt;
  logic [31:0] limit_r, limit_nxt;

  logic        accept;
  logic [31:0] limit_eff;
  logic        len_chk;
  logic [63:0] len_val;
  logic        len_over;
  logic        start_pl;
  logic [63:0] start_len;
  logic        done;
  logic        fail;
  err_t        fail_code;
  logic [63:0] ext_len;
  logic [2:0]  hbc_inc;
  logic [7:0]  key_byte;
  logic        pl_last;
  push_t       push_c;

  // Stall only on a full queue; bytes that give no result still wait
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign limit_eff = (limit_r == 32'd0) ? DEFAULT_MAX_FRAME : limit_r;
  assign limit_nxt = cfg_we ? cfg_wdata : limit_r;
  assign ext_len   = {rem_r[55:0], in_rx_byte};
  assign hbc_inc   = hbc_r + 3'd1;
  assign len_over  = (len_val[63:32] != 32'd0) || (len_val[31:0] > limit_eff);
  assign pl_last   = (rem_r[63:1] == 63'd0);

  // Pick the key byte for the current payload position
  always_comb begin
    unique case (pos_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      2'd3: key_byte = key_r[7:0];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Advance the frame parser by one byte
  always_comb begin
    phase_nxt   = phase_r;
    opcode_nxt  = opcode_r;
    fin_nxt     = fin_r;
    masked_nxt  = masked_r;
    rem_nxt     = rem_r;
    hbc_nxt     = hbc_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    stopped_nxt = stopped_r;
    len_chk     = 1'b0;
    len_val     = ext_len;
    start_pl    = 1'b0;
    start_len   = rem_r;
    done        = 1'b0;
    fail        = 1'b0;
    fail_code   = ERR_NONE;
    push_c      = '0;

    if (accept && !stopped_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt    = in_rx_byte[7];
          opcode_nxt = in_rx_byte[3:0];
          masked_nxt = 1'b0;
          rem_nxt    = 64'd0;
          hbc_nxt    = 3'd0;
          key_nxt    = 32'd0;
          pos_nxt    = 2'd0;
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = in_rx_byte[7];
          if (!fin_r) begin
            fail      = 1'b1;
            fail_code = ERR_FRAGMENT;
          end else begin
            hbc_nxt = 3'd0;
            rem_nxt = 64'd0;
            if (in_rx_byte[6:0] == LEN_EXT16) begin
              phase_nxt = PH_EXT16;
            end else if (in_rx_byte[6:0] == LEN_EXT64) begin
              phase_nxt = PH_EXT64;
            end else begin
              rem_nxt = {57'd0, in_rx_byte[6:0]};
              len_val = {57'd0, in_rx_byte[6:0]};
              len_chk = 1'b1;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          rem_nxt = ext_len;
          hbc_nxt = hbc_inc;
          if ((phase_r == PH_EXT16 && hbc_inc == 3'd2) ||
              (phase_r == PH_EXT64 && hbc_inc == 3'd0)) begin
            len_chk = 1'b1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_rx_byte};
          hbc_nxt = hbc_inc;
          if (hbc_inc == 3'd4) begin
            hbc_nxt  = 3'd0;
            start_pl = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_r + 2'd1;
          if (rem_r != 64'd0) begin
            rem_nxt = rem_r - 64'd1;
          end
          if (opcode_r == OP_TEXT || opcode_r == OP_PING) begin
            push_c.valid            = 1'b1;
            push_c.entry.kind       = (opcode_r == OP_TEXT) ? KIND_TEXT : KIND_PING;
            push_c.entry.has_data   = 1'b1;
            push_c.entry.raw        = in_rx_byte;
            push_c.entry.key        = masked_r ? key_byte : 8'd0;
            push_c.entry.frame_end  = pl_last;
            push_c.entry.error_code = ERR_NONE;
            if (pl_last) begin
              phase_nxt = PH_HDR0;
            end
          end else if (pl_last) begin
            done = 1'b1;
          end
        end
        default: phase_nxt = PH_HDR0;
      endcase

      // Check a completed length, then go to mask key or payload
      if (len_chk) begin
        if (len_over) begin
          fail      = 1'b1;
          fail_code = ERR_TOO_LONG;
        end else if (!masked_nxt && opcode_r != OP_CLOSE) begin
          fail      = 1'b1;
          fail_code = ERR_UNMASKED;
        end else if (masked_nxt) begin
          phase_nxt = PH_MASK;
          hbc_nxt   = 3'd0;
          key_nxt   = 32'd0;
        end else begin
          start_pl  = 1'b1;
          start_len = len_val;
        end
      end

      // Enter the payload, or close out an empty frame at once
      if (start_pl) begin
        pos_nxt = 2'd0;
        if (start_len == 64'd0) begin
          done = 1'b1;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end

      // Give the closing result of a frame whose payload is used up
      if (done) begin
        phase_nxt = PH_HDR0;
        priority if (opcode_r == OP_TEXT || opcode_r == OP_PING) begin
          push_c.valid            = 1'b1;
          push_c.entry.kind       = (opcode_r == OP_TEXT) ? KIND_TEXT : KIND_PING;
          push_c.entry.frame_end  = 1'b1;
          push_c.entry.error_code = ERR_NONE;
        end else if (opcode_r == OP_CLOSE) begin
          stopped_nxt             = 1'b1;
          push_c.valid            = 1'b1;
          push_c.entry.kind       = KIND_CLOSE;
          push_c.entry.frame_end  = 1'b1;
          push_c.entry.error_code = ERR_NONE;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_OPCODE;
        end
      end

      // Report an error and stop until reset
      if (fail) begin
        stopped_nxt             = 1'b1;
        phase_nxt               = PH_HDR0;
        push_c.valid            = 1'b1;
        push_c.entry.kind       = KIND_ERROR;
        push_c.entry.has_data   = 1'b0;
        push_c.entry.raw        = 8'd0;
        push_c.entry.key        = 8'd0;
        push_c.entry.frame_end  = 1'b1;
        push_c.entry.error_code = fail_code;
      end
    end
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      opcode_r  <= 4'd0;
      fin_r     <= 1'b0;
      masked_r  <= 1'b0;
      rem_r     <= 64'd0;
      hbc_r     <= 3'd0;
      key_r     <= 32'd0;
      pos_r     <= 2'd0;
      stopped_r <= 1'b0;
      limit_r   <= LIMIT_RESET;
    end else begin
      phase_r   <= phase_nxt;
      opcode_r  <= opcode_nxt;
      fin_r     <= fin_nxt;
      masked_r  <= masked_nxt;
      rem_r     <= rem_nxt;
      hbc_r     <= hbc_nxt;
      key_r     <= key_nxt;
      pos_r     <= pos_nxt;
      stopped_r <= stopped_nxt;
      limit_r   <= limit_nxt;
    end
  end

  // Once stopped, the parser stays stopped until reset
  assert property (@(posedge clk) disable iff (!rst_n) stopped_r |=> stopped_r)
    else $error("parser left the stopped state without reset");

  // A close or error result always stops the parser
  assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && (push.entry.kind == KIND_ERROR || push.entry.kind == KIND_CLOSE)
    |=> stopped_r)
    else $error("close or error result did not stop the parser");

  // Nothing is pushed while stopped or into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (!stopped_r && !q_full))
    else $error("result pushed while stopped or queue full");

endmodule

### hdl/wsfr_queue.sv
// Small result queue between the parser and the output stage.
module wsfr_queue
  import wsfr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Fill level never exceeds the depth
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill level above depth");

endmodule

### hdl/wsfr_back.sv
// Output stage: unmasks queued payload bytes and holds the result register.
module wsfr_back
  import wsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic       out_has_data,
  output logic [7:0] out_data,
  output logic       out_frame_end,
  output logic [2:0] out_error_code
);

  logic       valid_r, valid_nxt;
  kind_t      kind_r;
  logic       has_data_r;
  logic [7:0] data_r;
  logic       frame_end_r;
  err_t       error_code_r;

  // Take the next entry when the output register is free or being drained
  assign q_pop     = !q_empty && (!valid_r || !out_stall);
  assign valid_nxt = q_pop ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Unmask and load the result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r       <= head.kind;
      has_data_r   <= head.has_data;
      data_r       <= head.raw ^ head.key;
      frame_end_r  <= head.frame_end;
      error_code_r <= head.error_code;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_has_data   = has_data_r;
  assign out_data       = data_r;
  assign out_frame_end  = frame_end_r;
  assign out_error_code = error_code_r;

endmodule

### hdl/websocket_frame_receiver.sv
// Top level of the WebSocket client-to-server frame receiver.
// Takes one received byte per transfer and one byte per clock cycle, stalling
// only when the result queue (QUEUE_DEPTH entries) is full. The parser updates
// its frame state in the cycle of the transfer and pushes any result into the
// queue; the output stage pops it from the queue, unmasks it and loads it into
// its output register, which holds it while out_stall is high. Text and ping
// payload bytes come out with has_data set, the last one with frame_end; an
// empty text or ping frame gives one result without data. A close result or
// any error stops the block: later bytes are taken and dropped until reset.
// cfg_wdata written with cfg_we sets the largest payload length; zero selects
// 1 MiB. Write it only while the block is idle.
module websocket_frame_receiver
  import wsfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic        out_has_data,
  output logic [7:0]  out_data,
  output logic        out_frame_end,
  output logic [2:0]  out_error_code,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  push_t  push;
  entry_t head;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  wsfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .push       (push)
  );

  wsfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  wsfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_has_data   (out_has_data),
    .out_data       (out_data),
    .out_frame_end  (out_frame_end),
    .out_error_code (out_error_code)
  );

endmodule

### sim/ws_frame_checker.sv
// Result predictor and checker for the WebSocket frame receiver.
module ws_frame_checker
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic        out_has_data,
  input  logic [7:0]  out_data,
  input  logic        out_frame_end,
  input  logic [2:0]  out_error_code,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [2:0] {
    P_HDR0,
    P_HDR1,
    P_EXT16,
    P_EXT64,
    P_MASK,
    P_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    kind_t      kind;
    logic       has_data;
    logic [7:0] data;
    logic       frame_end;
    err_t       error_code;
  } ws_event_t;

  // Predicted receiver state
  logic [31:0]  frame_limit;
  parse_phase_t phase;
  logic [3:0]   opcode;
  logic         masked;
  logic         fin;
  logic [63:0]  remaining;
  logic [2:0]   hdr_count;
  logic [31:0]  key;
  logic [1:0]   key_pos;
  logic         halted;

  ws_event_t expected_events[$];
  int        mismatches = 0;

  // Stop the receiver with an error result
  function automatic bit halt_on(input err_t code, output ws_event_t ev);
    halted = 1'b1;
    phase  = P_HDR0;
    ev = '0;
    ev.kind       = KIND_ERROR;
    ev.frame_end  = 1'b1;
    ev.error_code = code;
    return 1'b1;
  endfunction

  // Payload used up: give the closing result of the frame
  function automatic bit close_frame(output ws_event_t ev);
    phase = P_HDR0;
    ev = '0;
    ev.frame_end = 1'b1;
    case (opcode)
      OP_TEXT: ev.kind = KIND_TEXT;
      OP_PING: ev.kind = KIND_PING;
      OP_CLOSE: begin
        halted  = 1'b1;
        ev.kind = KIND_CLOSE;
      end
      default: return halt_on(ERR_OPCODE, ev);
    endcase
    return 1'b1;
  endfunction

  function automatic bit begin_payload(output ws_event_t ev);
    key_pos = 2'd0;
    if (remaining == 64'd0) return close_frame(ev);
    phase = P_PAYLOAD;
    return 1'b0;
  endfunction

  // Length complete: check it, then go on to the key or the payload
  function automatic bit end_of_length(output ws_event_t ev);
    logic [63:0] lim;
    lim = (frame_limit == 32'd0) ? {32'd0, DEFAULT_MAX_FRAME} : {32'd0, frame_limit};
    if (remaining > lim) return halt_on(ERR_TOO_LONG, ev);
    if (!masked && opcode != OP_CLOSE) return halt_on(ERR_UNMASKED, ev);
    if (masked) begin
      phase     = P_MASK;
      hdr_count = 3'd0;
      key       = 32'd0;
      return 1'b0;
    end
    return begin_payload(ev);
  endfunction

  // Advance the parser by one received byte; return 1 when it gives a result
  function automatic bit deframe_byte(input logic [7:0] b, output ws_event_t ev);
    logic [7:0] plain;
    ev = '0;
    if (halted) return 1'b0;
    case (phase)
      P_HDR0: begin
        fin       = b[7];
        opcode    = b[3:0];
        masked    = 1'b0;
        remaining = 64'd0;
        hdr_count = 3'd0;
        key       = 32'd0;
        key_pos   = 2'd0;
        phase     = P_HDR1;
      end
      P_HDR1: begin
        masked = b[7];
        if (!fin) return halt_on(ERR_FRAGMENT, ev);
        hdr_count = 3'd0;
        remaining = 64'd0;
        if (b[6:0] == LEN_EXT16) phase = P_EXT16;
        else if (b[6:0] == LEN_EXT64) phase = P_EXT64;
        else begin
          remaining = {57'd0, b[6:0]};
          return end_of_length(ev);
        end
      end
      P_EXT16, P_EXT64: begin
        remaining = {remaining[55:0], b};
        hdr_count = hdr_count + 3'd1;
        if ((phase == P_EXT16 && hdr_count == 3'd2) ||
            (phase == P_EXT64 && hdr_count == 3'd0))
          return end_of_length(ev);
      end
      P_MASK: begin
        key       = {key[23:0], b};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count == 3'd4) begin
          hdr_count = 3'd0;
          return begin_payload(ev);
        end
      end
      P_PAYLOAD: begin
        plain   = masked ? (b ^ key[8*(3-key_pos) +: 8]) : b;
        key_pos = key_pos + 2'd1;
        if (remaining != 64'd0) remaining = remaining - 64'd1;
        if (opcode == OP_TEXT || opcode == OP_PING) begin
          if (remaining == 64'd0) phase = P_HDR0;
          ev.kind       = (opcode == OP_TEXT) ? KIND_TEXT : KIND_PING;
          ev.has_data   = 1'b1;
          ev.data       = plain;
          ev.frame_end  = (remaining == 64'd0);
          ev.error_code = ERR_NONE;
          return 1'b1;
        end
        if (remaining == 64'd0) return close_frame(ev);
      end
      default: phase = P_HDR0;
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    ws_event_t ev;
    ws_event_t want;
    if (!rst_n) begin
      frame_limit = LIMIT_RESET;
      phase       = P_HDR0;
      opcode      = 4'd0;
      masked      = 1'b0;
      fin         = 1'b0;
      remaining   = 64'd0;
      hdr_count   = 3'd0;
      key         = 32'd0;
      key_pos     = 2'd0;
      halted      = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_we) frame_limit = cfg_wdata;
      // Predict the input transfer
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_rx_byte, ev)) expected_events.push_back(ev);
      end
      // Compare the output transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("result with nothing predicted: kind %0d data %0d end %0d code %0d",
                 out_kind, out_data, out_frame_end, out_error_code);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("has_data", want.has_data, out_has_data);
          check_field("data", want.data, out_data);
          check_field("frame_end", want.frame_end, out_frame_end);
          check_field("error_code", want.error_code, out_error_code);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_events.size();
  end

endmodule

### sim/websocket_frame_receiver_tb.sv
// Stimulus, clock, reset and verdict for the WebSocket frame receiver.
module websocket_frame_receiver_tb;
  import wsfr_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam logic [7:0] TOP_BIT = 8'h80;

  typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_t;
  typedef enum int {
    END_CLOSE_MASKED,
    END_CLOSE_PLAIN,
    END_FRAGMENT,
    END_TOO_LONG,
    END_UNMASKED,
    END_BAD_OPCODE
  } ending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic        out_has_data;
  logic [7:0]  out_data;
  logic        out_frame_end;
  logic [2:0]  out_error_code;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;

  int fail_count;
  int pending;
  int sent = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  always #2 clk = ~clk;

  websocket_frame_receiver DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_has_data   (out_has_data),
    .out_data       (out_data),
    .out_frame_end  (out_frame_end),
    .out_error_code (out_error_code),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  ws_frame_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_has_data   (out_has_data),
    .out_data       (out_data),
    .out_frame_end  (out_frame_end),
    .out_error_code (out_error_code),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !no_idle && ($urandom_range(99) < 15);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Hold the input until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Send header, length, key and body bytes of one frame
  task automatic send_frame(input logic [3:0] op, input bit fin, input bit mask,
                            input logic [63:0] len, input len_form_t form,
                            input int body);
    logic [2:0] rsv;
    rsv = 3'($urandom);
    if (len > 64'd65535) form = LEN_64;
    else if (len > 64'd125 && form == LEN_SHORT) form = LEN_16;
    send_byte({fin, rsv, op});
    case (form)
      LEN_SHORT: send_byte({mask, len[6:0]});
      LEN_16: begin
        send_byte({mask, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (mask) for (int i = 0; i < 4; i++) send_byte(8'($urandom));
    for (int i = 0; i < body; i++) send_byte(8'($urandom));
  endtask

  // Well-formed masked text or ping frames, lengths up to cap
  task automatic run_frames(input int target, input int cap);
    logic [63:0] len;
    int r;
    while (sent < target) begin
      r   = $urandom_range(9);
      len = 64'(($urandom_range(7) == 0) ? cap : int'($urandom_range(cap)));
      send_frame($urandom_range(1) ? OP_TEXT : OP_PING, 1'b1, 1'b1, len,
                 r < 6 ? LEN_SHORT : (r < 8 ? LEN_16 : LEN_64), int'(len));
    end
  endtask

  // Finish the session with a close or an error, then feed dropped bytes
  task automatic send_closing(input logic [31:0] lim);
    logic [3:0]  op;
    logic [63:0] len;
    len_form_t   form;
    form = len_form_t'($urandom_range(2));
    len  = 64'($urandom_range(lim < 32'd20 ? lim : 32'd20));
    case (ending_t'($urandom_range(5)))
      END_CLOSE_MASKED: send_frame(OP_CLOSE, 1'b1, 1'b1, len, form, int'(len));
      END_CLOSE_PLAIN:  send_frame(OP_CLOSE, 1'b1, 1'b0, len, form, int'(len));
      END_FRAGMENT:     send_frame(4'($urandom), 1'b0, 1'($urandom), len, form, 3);
      END_TOO_LONG: begin
        if ($urandom_range(1)) len = {1'b1, 31'($urandom), 32'($urandom)};
        else len = {32'd0, lim} + 64'd1;
        send_frame(4'($urandom), 1'b1, 1'($urandom), len, form, 4);
      end
      END_UNMASKED:
        send_frame($urandom_range(1) ? OP_TEXT : OP_PING, 1'b1, 1'b0, len, form, 3);
      default: begin
        do op = 4'($urandom); while (op == OP_TEXT || op == OP_PING || op == OP_CLOSE);
        send_frame(op, 1'b1, 1'b1, len, form, int'(len));
      end
    endcase
    repeat (8) send_byte(8'($urandom));
  endtask

  initial begin
    logic [7:0]  opening [20];
    logic [31:0] lim;
    // Empty text, empty ping, and a two-byte text with an all-ones key
    opening = '{TOP_BIT | OP_TEXT, TOP_BIT, 8'h5a, 8'hc3, 8'h00, 8'hff,
                TOP_BIT | OP_PING, TOP_BIT, 8'h12, 8'h34, 8'h56, 8'h78,
                TOP_BIT | OP_TEXT, TOP_BIT | 8'd2, 8'hff, 8'hff, 8'hff, 8'hff,
                8'h00, 8'hff};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (opening[i]) send_byte(opening[i]);

    // Zero selects the default limit
    write_limit(32'd0);
    run_frames(450, 80);
    // Smallest nonzero limit: frames of zero or one byte
    write_limit(32'd1);
    run_frames(700, 1);
    // Largest limit, with no idling on either side
    write_limit(32'hffff_ffff);
    no_idle <= 1'b1;
    run_frames(1100, 80);
    drain();
    no_idle <= 1'b0;
    lim = $urandom_range(100, 2);
    write_limit(lim);
    run_frames(1430, int'(lim));

    send_closing(lim);
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### websocket_frame_receiver.f
hdl/wsfr_pkg.sv
hdl/wsfr_front.sv
hdl/wsfr_queue.sv
hdl/wsfr_back.sv
hdl/websocket_frame_receiver.sv
sim/ws_frame_checker.sv
sim/websocket_frame_receiver_tb.sv
